[hdl/pbd_pkg.sv]
package pbd_pkg;

  // Field and state widths.
  localparam int unsigned PitchW  = 12;
  localparam int unsigned GainW   = 10;
  localparam int unsigned DutyW   = 14;
  localparam int unsigned PeriodW = 8;
  localparam int unsigned HistW   = 3;
  localparam int unsigned KickW   = 4;
  localparam int unsigned ByteW   = 8;

  // Configuration port.
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  // Defaults for the top-level parameters.
  localparam int unsigned DefDebounceTicks = 20;
  localparam int unsigned DefPwmPeriod     = 10000;

  // Pitch limit: a magnitude above 181 degrees reads as zero.
  localparam logic [14:0] PitchMax = 15'd2896;

  // Deviation thresholds, all in sixteenths of a degree.
  localparam logic [PitchW-1:0] BandLimit = 12'd480;
  localparam logic [PitchW-1:0] FarLimit  = 12'd272;
  localparam logic [PitchW-1:0] MidLimit  = 12'd112;
  localparam logic [PitchW-1:0] NearLimit = 12'd64;
  localparam logic [PitchW-1:0] FineLimit = 12'd16;

  // Start kick: total length and the number of leading drive ticks.
  localparam logic [KickW-1:0] KickTicks   = 4'd12;
  localparam logic [KickW-1:0] KickOnTicks = 4'd2;
  localparam logic [KickW-1:0] KickOffLast = KickTicks - KickOnTicks;

  // Register reset values.
  localparam logic [PitchW-1:0]  RstTarget = 12'd1488;
  localparam logic [GainW-1:0]   RstGain   = 10'd225;
  localparam logic [DutyW-1:0]   RstFar    = 14'd6000;
  localparam logic [DutyW-1:0]   RstMid    = 14'd5000;
  localparam logic [DutyW-1:0]   RstNear   = 14'd3000;
  localparam logic [DutyW-1:0]   RstFine   = 14'd2500;
  localparam logic [PeriodW-1:0] RstPeriod = 8'd20;

  typedef enum logic [2:0] {
    RegTarget = 3'd0,
    RegGain   = 3'd1,
    RegFar    = 3'd2,
    RegMid    = 3'd3,
    RegNear   = 3'd4,
    RegFine   = 3'd5,
    RegPeriod = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic             switch_level;
    logic             sample_valid;
    logic [ByteW-1:0] pitch_high;
    logic [ByteW-1:0] pitch_low;
    logic             sensor_ok;
  } in_word_t;

  typedef struct packed {
    logic [DutyW-1:0] forward_duty;
    logic [DutyW-1:0] backward_duty;
    logic             motor_enabled;
    logic             kick_active;
  } out_word_t;

  // Result of one control evaluation, handed from the evaluator to the top.
  typedef struct packed {
    logic [DutyW-1:0] held_duty;
    logic             set_levels;
    logic [DutyW-1:0] forward_level;
    logic [DutyW-1:0] backward_level;
    logic             start_kick;
    logic             kick_forward;
  } eval_t;

endpackage

[hdl/pbd_if.sv]
interface pbd_in_if;
  import pbd_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pbd_out_if;
  import pbd_pkg::*;

  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/pbd_eval.sv]
module pbd_eval #(
  parameter int unsigned PwmPeriod = pbd_pkg::DefPwmPeriod
) (
  input  logic [pbd_pkg::PitchW-1:0] pitch_i,
  input  logic [pbd_pkg::PitchW-1:0] target_i,
  input  logic [pbd_pkg::GainW-1:0]  gain_i,
  input  logic [pbd_pkg::DutyW-1:0]  speed_far_i,
  input  logic [pbd_pkg::DutyW-1:0]  speed_mid_i,
  input  logic [pbd_pkg::DutyW-1:0]  speed_near_i,
  input  logic [pbd_pkg::DutyW-1:0]  speed_fine_i,
  input  logic [pbd_pkg::DutyW-1:0]  held_duty_i,
  output pbd_pkg::eval_t             eval_o
);
  import pbd_pkg::*;

  localparam int unsigned ProdW   = GainW + PitchW;
  localparam int unsigned ScaledW = ProdW - 4;
  localparam logic [ScaledW-1:0] SatLimit = ScaledW'(PwmPeriod);

  logic              above;
  logic [PitchW-1:0] dev;
  logic [ProdW-1:0]  prod;
  logic [ScaledW-1:0] scaled;
  logic [DutyW-1:0]  prop_duty;
  logic [DutyW-1:0]  band_duty;

  assign above  = pitch_i > target_i;
  assign dev    = above ? (pitch_i - target_i) : (target_i - pitch_i);
  // Gain is in duty counts per degree; dividing by 16 turns sixteenths into degrees.
  assign prod   = ProdW'(gain_i) * ProdW'(dev);
  assign scaled = prod[ProdW-1:4];
  assign prop_duty = (scaled > SatLimit) ? DutyW'(SatLimit) : scaled[DutyW-1:0];

  always_comb begin
    if (dev > FarLimit) begin
      band_duty = speed_far_i;
    end else if (dev > MidLimit) begin
      band_duty = speed_mid_i;
    end else if (dev > NearLimit) begin
      band_duty = speed_near_i;
    end else if (dev > FineLimit) begin
      band_duty = speed_fine_i;
    end else begin
      band_duty = held_duty_i;
    end
  end

  always_comb begin
    eval_o = '0;
    if (dev < BandLimit) begin
      eval_o.held_duty = band_duty;
      // On target the levels stay and no kick starts.
      if (pitch_i != target_i) begin
        eval_o.set_levels     = 1'b1;
        eval_o.start_kick     = 1'b1;
        eval_o.kick_forward   = above;
        eval_o.forward_level  = above ? band_duty : '0;
        eval_o.backward_level = above ? '0 : band_duty;
      end
    end else begin
      eval_o.held_duty      = prop_duty;
      eval_o.set_levels     = 1'b1;
      eval_o.forward_level  = above ? prop_duty : '0;
      eval_o.backward_level = above ? '0 : prop_duty;
    end
  end

endmodule

[hdl/pendulum_balance_drive.sv]
// Each input word passes the input register, then the result register.
// Throughput: one word per cycle while the result side is ready; a stall
// there holds both registers and then stops the input.
// Reset: rst_ni is asynchronous and active low; it clears all control state and
// restores the configuration registers to their defaults.
module pendulum_balance_drive #(
  parameter int unsigned DebounceTicks = pbd_pkg::DefDebounceTicks,
  parameter int unsigned PwmPeriod     = pbd_pkg::DefPwmPeriod
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  pbd_in_if.sink                    in_i,
  pbd_out_if.source                 out_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [pbd_pkg::AddrW-1:0] paddr,
  input  logic [pbd_pkg::DataW-1:0] pwdata,
  output logic [pbd_pkg::DataW-1:0] prdata,
  output logic                      pready
);
  import pbd_pkg::*;

  localparam int unsigned DbW = $clog2(DebounceTicks);
  localparam logic [DbW-1:0] DbLast = DbW'(DebounceTicks - 1);

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes complete in the APB access phase; the
  // port never stalls. Register i sits at byte address 4*i.
  // ---------------------------------------------------------------------------
  logic [PitchW-1:0]  target_q;
  logic [GainW-1:0]   gain_q;
  logic [DutyW-1:0]   far_q, mid_q, near_q, fine_q;
  logic [PeriodW-1:0] period_q;
  logic               cfg_wr;
  reg_idx_e           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[AddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= RstTarget;
      gain_q   <= RstGain;
      far_q    <= RstFar;
      mid_q    <= RstMid;
      near_q   <= RstNear;
      fine_q   <= RstFine;
      period_q <= RstPeriod;
    end else if (cfg_wr) begin
      case (cfg_idx)
        RegTarget: target_q <= pwdata[PitchW-1:0];
        RegGain:   gain_q   <= pwdata[GainW-1:0];
        RegFar:    far_q    <= pwdata[DutyW-1:0];
        RegMid:    mid_q    <= pwdata[DutyW-1:0];
        RegNear:   near_q   <= pwdata[DutyW-1:0];
        RegFine:   fine_q   <= pwdata[DutyW-1:0];
        RegPeriod: period_q <= pwdata[PeriodW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      RegTarget: prdata = DataW'(target_q);
      RegGain:   prdata = DataW'(gain_q);
      RegFar:    prdata = DataW'(far_q);
      RegMid:    prdata = DataW'(mid_q);
      RegNear:   prdata = DataW'(near_q);
      RegFine:   prdata = DataW'(fine_q);
      RegPeriod: prdata = DataW'(period_q);
      default:   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline handshake. The input register holds one tick word; it moves on
  // into the result register whenever that register is empty or being drained,
  // and at that same edge the block state advances by one tick. A new word is
  // taken whenever the input register is empty or moving on, so a waiting
  // result blocks the input only once the input register is full.
  // ---------------------------------------------------------------------------
  in_word_t  in_q;
  logic      in_vld_q;
  out_word_t out_q, out_d;
  logic      out_vld_q;
  logic      advance;

  assign advance    = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_q <= in_i.data;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  // ---------------------------------------------------------------------------
  // Tick state.
  // ---------------------------------------------------------------------------
  logic [HistW-1:0]   hist_q, hist_d;
  logic               stable_q, stable_d;
  logic               prev_q, prev_d;
  logic [DbW-1:0]     db_cnt_q, db_cnt_d;
  logic [PeriodW-1:0] ctl_cnt_q, ctl_cnt_d;
  logic               pend_q, pend_d;
  logic               drive_q, drive_d;
  logic [PitchW-1:0]  pitch_q, pitch_d;
  logic [DutyW-1:0]   held_q, held_d;
  logic [DutyW-1:0]   fwd_q, fwd_d;
  logic [DutyW-1:0]   bwd_q, bwd_d;
  logic [KickW-1:0]   kick_q, kick_d;
  logic               kick_fwd_q, kick_fwd_d;

  // Intermediate values of the tick, in the order the tick applies them.
  logic [HistW-1:0]   hist_n;
  logic               stable_n;
  logic               toggle;
  logic [14:0]        raw_pitch;
  logic [PeriodW-1:0] period_eff;
  logic               ctl_fire;
  logic [KickW-1:0]   kick_n;
  logic               run_eval;
  eval_t              eval;

  assign raw_pitch = {in_q.pitch_high[ByteW-2:0], in_q.pitch_low};

  // Pitch capture from a valid sample with the sensor ok: drop the sign bit, and treat anything past the limit as 0.
  always_comb begin
    pitch_d = pitch_q;
    if (in_q.sample_valid && in_q.sensor_ok) begin
      pitch_d = (raw_pitch > PitchMax) ? '0 : raw_pitch[PitchW-1:0];
    end
  end

  // The evaluator sees the pitch as captured in this very tick.
  pbd_eval #(
    .PwmPeriod(PwmPeriod)
  ) u_eval (
    .pitch_i      (pitch_d),
    .target_i     (target_q),
    .gain_i       (gain_q),
    .speed_far_i  (far_q),
    .speed_mid_i  (mid_q),
    .speed_near_i (near_q),
    .speed_fine_i (fine_q),
    .held_duty_i  (held_q),
    .eval_o       (eval)
  );

  always_comb begin
    hist_d     = hist_q;
    stable_d   = stable_q;
    prev_d     = prev_q;
    drive_d    = drive_q;
    fwd_d      = fwd_q;
    bwd_d      = bwd_q;
    held_d     = held_q;
    kick_fwd_d = kick_fwd_q;
    pend_d     = pend_q;
    kick_n     = kick_q;

    // Debounce: sample the switch once every DebounceTicks ticks. Three equal
    // samples in a row settle the stable level; its rising edge toggles the
    // drive, and switching off clears both levels and any running kick.
    hist_n   = {hist_q[HistW-2:0], in_q.switch_level};
    stable_n = ((hist_n == '0) || (hist_n == '1)) ? in_q.switch_level : stable_q;
    toggle   = stable_n && !prev_q;
    if (db_cnt_q == DbLast) begin
      db_cnt_d = '0;
      hist_d   = hist_n;
      stable_d = stable_n;
      prev_d   = stable_n;
      if (toggle) begin
        drive_d = !drive_q;
        if (drive_q) begin
          fwd_d  = '0;
          bwd_d  = '0;
          kick_n = '0;
        end
      end
    end else begin
      db_cnt_d = db_cnt_q + 1'b1;
    end

    // Control request. A period of zero behaves as one, and a period lowered
    // below the running count ends the count at once.
    period_eff = (period_q == '0) ? PeriodW'(1) : period_q;
    ctl_fire   = ({1'b0, ctl_cnt_q} + 1'b1) >= {1'b0, period_eff};
    if (ctl_fire) begin
      ctl_cnt_d = '0;
      pend_d    = in_q.sensor_ok;
    end else begin
      ctl_cnt_d = ctl_cnt_q + 1'b1;
    end

    // The kick counts down first; an evaluation waits for it to finish.
    if (kick_n != '0) begin
      kick_n = kick_n - 1'b1;
    end

    run_eval = pend_d && (kick_n == '0);
    kick_d   = kick_n;
    if (run_eval) begin
      pend_d = 1'b0;
      if (drive_d) begin
        held_d = eval.held_duty;
        if (eval.set_levels) begin
          fwd_d = eval.forward_level;
          bwd_d = eval.backward_level;
        end
        if (eval.start_kick) begin
          kick_d     = KickTicks;
          kick_fwd_d = eval.kick_forward;
        end
      end
    end

    // Output word. After the first drive ticks of a kick the driven channel
    // is held at zero until the kick runs out.
    out_d.forward_duty  = fwd_d;
    out_d.backward_duty = bwd_d;
    if ((kick_d != '0) && (kick_d <= KickOffLast)) begin
      if (kick_fwd_d) begin
        out_d.forward_duty = '0;
      end else begin
        out_d.backward_duty = '0;
      end
    end
    out_d.motor_enabled = drive_d;
    out_d.kick_active   = kick_d != '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q     <= '0;
      stable_q   <= 1'b0;
      prev_q     <= 1'b0;
      db_cnt_q   <= '0;
      ctl_cnt_q  <= '0;
      pend_q     <= 1'b0;
      drive_q    <= 1'b0;
      pitch_q    <= '0;
      held_q     <= '0;
      fwd_q      <= '0;
      bwd_q      <= '0;
      kick_q     <= '0;
      kick_fwd_q <= 1'b0;
    end else if (advance) begin
      hist_q     <= hist_d;
      stable_q   <= stable_d;
      prev_q     <= prev_d;
      db_cnt_q   <= db_cnt_d;
      ctl_cnt_q  <= ctl_cnt_d;
      pend_q     <= pend_d;
      drive_q    <= drive_d;
      pitch_q    <= pitch_d;
      held_q     <= held_d;
      fwd_q      <= fwd_d;
      bwd_q      <= bwd_d;
      kick_q     <= kick_d;
      kick_fwd_q <= kick_fwd_d;
    end
  end

endmodule

[tb/testbench.sv]
module testbench;
  import pbd_pkg::*;

  // The block under test sees one word per millisecond tick and answers every
  // accepted word with exactly one result word, registered in the input and
  // then the result register. The scoreboard below keeps its own copy of the
  // drive state. It works out the result of each accepted tick and checks the
  // result words in order.
  class drive_scoreboard;
    // Copy of the configuration registers.
    logic [PitchW-1:0]  target;
    logic [GainW-1:0]   gain;
    logic [DutyW-1:0]   spd_far;
    logic [DutyW-1:0]   spd_mid;
    logic [DutyW-1:0]   spd_near;
    logic [DutyW-1:0]   spd_fine;
    logic [PeriodW-1:0] period;

    // Copy of the drive state.
    logic [HistW-1:0] sw_hist;
    logic             sw_stable;
    logic             sw_prev;
    int unsigned      deb_cnt;
    int unsigned      ctl_cnt;
    logic             ctl_pending;
    logic             drive_on;
    logic [PitchW-1:0] pitch;
    logic [DutyW-1:0] held;
    logic [DutyW-1:0] fwd_lvl;
    logic [DutyW-1:0] bwd_lvl;
    int unsigned      kick_cnt;
    logic             kick_fwd;

    out_word_t   duty_queue[$];
    int unsigned errors;

    function new();
      target = RstTarget;
      gain = RstGain;
      spd_far = RstFar;
      spd_mid = RstMid;
      spd_near = RstNear;
      spd_fine = RstFine;
      period = RstPeriod;
      sw_hist = '0;
      sw_stable = 1'b0;
      sw_prev = 1'b0;
      deb_cnt = 0;
      ctl_cnt = 0;
      ctl_pending = 1'b0;
      drive_on = 1'b0;
      pitch = '0;
      held = '0;
      fwd_lvl = '0;
      bwd_lvl = '0;
      kick_cnt = 0;
      kick_fwd = 1'b0;
      errors = 0;
    endfunction

    // Prints one line for the mismatch and counts it.
    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    function int unsigned pending();
      return duty_queue.size();
    endfunction

    // Keeps the written value at the register's width and returns what a
    // read of that register should give back.
    function logic [DataW-1:0] set_register(reg_idx_e idx, logic [DataW-1:0] value);
      case (idx)
        RegTarget: begin
          target = value[PitchW-1:0];
          return DataW'(target);
        end
        RegGain: begin
          gain = value[GainW-1:0];
          return DataW'(gain);
        end
        RegFar: begin
          spd_far = value[DutyW-1:0];
          return DataW'(spd_far);
        end
        RegMid: begin
          spd_mid = value[DutyW-1:0];
          return DataW'(spd_mid);
        end
        RegNear: begin
          spd_near = value[DutyW-1:0];
          return DataW'(spd_near);
        end
        RegFine: begin
          spd_fine = value[DutyW-1:0];
          return DataW'(spd_fine);
        end
        default: begin
          period = value[PeriodW-1:0];
          return DataW'(period);
        end
      endcase
    endfunction

    // One control evaluation with the drive on.
    function void run_control();
      int unsigned dev;
      int unsigned duty;
      dev = (pitch > target) ? pitch - target : target - pitch;
      if (dev < BandLimit) begin
        if (dev > FarLimit) begin
          held = spd_far;
        end else if (dev > MidLimit) begin
          held = spd_mid;
        end else if (dev > NearLimit) begin
          held = spd_near;
        end else if (dev > FineLimit) begin
          held = spd_fine;
        end
        // Right on target nothing changes and no kick starts.
        if (pitch == target) begin
          return;
        end
        kick_fwd = pitch > target;
        fwd_lvl = kick_fwd ? held : '0;
        bwd_lvl = kick_fwd ? '0 : held;
        kick_cnt = KickTicks;
      end else begin
        duty = (int'(gain) * dev) >> 4;
        if (duty > DefPwmPeriod) begin
          duty = DefPwmPeriod;
        end
        held = duty[DutyW-1:0];
        fwd_lvl = (pitch > target) ? duty[DutyW-1:0] : '0;
        bwd_lvl = (pitch > target) ? '0 : duty[DutyW-1:0];
      end
    endfunction

    // Advances the state by one accepted tick and queues the result word.
    function void note_input(in_word_t w);
      out_word_t   o;
      logic [14:0] mag;
      int unsigned per;
      if (deb_cnt + 1 >= DefDebounceTicks) begin
        deb_cnt = 0;
        sw_hist = {sw_hist[HistW-2:0], w.switch_level};
        if (sw_hist == '0 || sw_hist == '1) begin
          sw_stable = w.switch_level;
        end
        if (sw_stable && !sw_prev) begin
          drive_on = !drive_on;
          if (!drive_on) begin
            fwd_lvl = '0;
            bwd_lvl = '0;
            kick_cnt = 0;
          end
        end
        sw_prev = sw_stable;
      end else begin
        deb_cnt++;
      end

      if (w.sample_valid && w.sensor_ok) begin
        mag = {w.pitch_high[6:0], w.pitch_low};
        pitch = (mag > PitchMax) ? '0 : mag[PitchW-1:0];
      end

      per = (period == '0) ? 1 : period;
      if (ctl_cnt + 1 >= per) begin
        ctl_cnt = 0;
        ctl_pending = w.sensor_ok;
      end else begin
        ctl_cnt++;
      end

      if (kick_cnt > 0) begin
        kick_cnt--;
      end

      if (ctl_pending && kick_cnt == 0) begin
        ctl_pending = 1'b0;
        if (drive_on) begin
          run_control();
        end
      end

      o.forward_duty = fwd_lvl;
      o.backward_duty = bwd_lvl;
      // The pause of the start kick blanks the driven channel.
      if (kick_cnt > 0 && kick_cnt <= KickOffLast) begin
        if (kick_fwd) begin
          o.forward_duty = '0;
        end else begin
          o.backward_duty = '0;
        end
      end
      o.motor_enabled = drive_on;
      o.kick_active = kick_cnt != 0;
      duty_queue.push_back(o);
    endfunction

    task check_result(out_word_t got);
      out_word_t want;
      if (duty_queue.size() == 0) begin
        report($sformatf("result word %h arrived with none expected", got));
        return;
      end
      want = duty_queue.pop_front();
      if (got.forward_duty !== want.forward_duty) begin
        report($sformatf("forward_duty %0d, expected %0d", got.forward_duty,
                         want.forward_duty));
      end
      if (got.backward_duty !== want.backward_duty) begin
        report($sformatf("backward_duty %0d, expected %0d", got.backward_duty,
                         want.backward_duty));
      end
      if (got.motor_enabled !== want.motor_enabled) begin
        report($sformatf("motor_enabled %b, expected %b", got.motor_enabled,
                         want.motor_enabled));
      end
      if (got.kick_active !== want.kick_active) begin
        report($sformatf("kick_active %b, expected %b", got.kick_active,
                         want.kick_active));
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  pbd_in_if  in_bus ();
  pbd_out_if out_bus ();

  drive_scoreboard sb;

  // While quiet is set neither side idles. The stimulus raises
  // hold_off_requests to make the result side stall for a long stretch.
  bit          quiet;
  int unsigned hold_off_requests;

  // Generator state of the user switch: current level and ticks left on it.
  bit          sw_level;
  int unsigned sw_run;

  pendulum_balance_drive u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Length of an idle stretch in cycles, drawn at random; now and then a long one.
  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 2);
    end else if (r < 95) begin
      return $urandom_range(3, 6);
    end
    return $urandom_range(10, 30);
  endfunction

  // A pitch magnitude that lands in the chosen deviation band around the
  // current set point. The bands are picked so that every threshold is hit
  // from both sides. A few values lie above the pitch limit or are drawn
  // over the whole 15-bit range.
  function automatic logic [14:0] pick_pitch();
    int unsigned r;
    int unsigned dev;
    int          v;
    int          tgt;
    r = $urandom_range(0, 99);
    if (r >= 96) begin
      return 15'($urandom_range(0, 32767));
    end else if (r >= 92) begin
      return 15'($urandom_range(int'(PitchMax) + 1, 32767));
    end
    if (r < 10) begin
      dev = 0;
    end else if (r < 24) begin
      dev = $urandom_range(1, 16);
    end else if (r < 38) begin
      dev = $urandom_range(17, 64);
    end else if (r < 52) begin
      dev = $urandom_range(65, 112);
    end else if (r < 66) begin
      dev = $urandom_range(113, 272);
    end else if (r < 80) begin
      dev = $urandom_range(273, 479);
    end else begin
      dev = $urandom_range(480, int'(PitchMax));
    end
    tgt = int'(sb.target);
    v = $urandom_range(0, 1) ? tgt + int'(dev) : tgt - int'(dev);
    // Mirror to the other side of the set point when one side has no room.
    if (v > int'(PitchMax)) begin
      v = tgt - int'(dev);
    end
    if (v < 0) begin
      v = tgt + int'(dev);
    end
    if (v < 0 || v > int'(PitchMax)) begin
      v = $urandom_range(0, int'(PitchMax));
    end
    return 15'(v);
  endfunction

  // Offers one tick word and waits until the block takes it. A gap before
  // the word lowers valid for a while. The word is noted at the edge of
  // acceptance.
  task automatic send_tick(in_word_t w);
    int unsigned gap;
    gap = (quiet || $urandom_range(0, 1) == 0) ? 0 : idle_length();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.data <= w;
    do @(posedge clk_i); while (!in_bus.ready);
    sb.note_input(w);
  endtask

  // Writes one register in a setup and an access phase and reads it back
  // at once. The bus is left idle at the end, so that calls in a row never
  // drive psel twice in one step.
  task automatic program_register(reg_idx_e idx, logic [DataW-1:0] value);
    logic [DataW-1:0] kept;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrW'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    kept = sb.set_register(idx, value);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== kept) begin
      sb.report($sformatf("register %s reads %h, expected %h", idx.name(), prdata, kept));
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(int unsigned tgt, int unsigned kp, int unsigned d_far,
                           int unsigned d_mid, int unsigned d_near,
                           int unsigned d_fine, int unsigned per);
    program_register(RegTarget, tgt);
    program_register(RegGain, kp);
    program_register(RegFar, d_far);
    program_register(RegMid, d_mid);
    program_register(RegNear, d_near);
    program_register(RegFine, d_fine);
    program_register(RegPeriod, per);
  endtask

  // Stops offering words and waits until every result word has come back,
  // with a bound in case the block hangs.
  task automatic wait_drained();
    int unsigned n;
    n = 0;
    in_bus.valid <= 1'b0;
    while (sb.pending() != 0 && n < 5000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  // Random ticks. The switch is held in runs long enough to pass the
  // debounce, so the drive really toggles, with the odd short bounce in
  // between. While the drive is on, the release lasts long, so that most
  // evaluations see an active drive. Part of every phase runs without any
  // idling, and once per phase the result side holds off for a long time.
  task automatic run_ticks(int unsigned count);
    in_word_t    w;
    logic [14:0] mag;
    for (int unsigned i = 0; i < count; i++) begin
      if (sw_run == 0) begin
        sw_level = !sw_level;
        if ($urandom_range(0, 9) == 0) begin
          sw_run = $urandom_range(1, 30);
        end else if (sw_level) begin
          sw_run = $urandom_range(60, 140);
        end else begin
          sw_run = sb.drive_on ? $urandom_range(150, 400) : $urandom_range(60, 100);
        end
      end
      sw_run--;
      quiet = (i >= 100 && i < 170);
      if (i == 200) begin
        hold_off_requests++;
      end
      mag = pick_pitch();
      w.switch_level = sw_level;
      w.sample_valid = $urandom_range(0, 9) < 7;
      w.pitch_high = {1'($urandom_range(0, 1)), mag[14:8]};
      w.pitch_low = mag[7:0];
      w.sensor_ok = $urandom_range(0, 19) != 0;
      send_tick(w);
    end
    quiet = 1'b0;
  endtask

  // Result side: checks every accepted result word and lowers ready at
  // random. A hold-off request makes it hold ready low while the stimulus
  // keeps offering ticks, long enough for the block to fill up and stall
  // its input.
  initial begin : result_sink
    int unsigned stall;
    int unsigned seen;
    stall = 0;
    seen = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
        sb.check_result(out_bus.data);
      end
      if (seen != hold_off_requests) begin
        seen = hold_off_requests;
        stall = 150;
      end else if (stall == 0 && !quiet && $urandom_range(0, 9) >= 7) begin
        stall = idle_length();
      end
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        stall--;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    sb = new();
    quiet = 1'b0;
    hold_off_requests = 0;
    sw_level = 1'b0;
    sw_run = 0;
    in_bus.valid <= 1'b0;
    in_bus.data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed ticks with the reset configuration: field extremes, a
    // pitch right at the limit and just above it, the sign bit set and
    // clear, readings while the sensor check fails or no sample comes in,
    // a pitch equal to the set point and one just a degree off.
    send_tick(in_word_t'{1'b0, 1'b0, 8'h00, 8'h00, 1'b0});
    send_tick(in_word_t'{1'b1, 1'b1, 8'hFF, 8'hFF, 1'b1});
    send_tick(in_word_t'{1'b0, 1'b1, 8'h8B, 8'h50, 1'b1});
    send_tick(in_word_t'{1'b1, 1'b1, 8'h0B, 8'h51, 1'b1});
    send_tick(in_word_t'{1'b0, 1'b1, 8'h03, 8'hE8, 1'b0});
    send_tick(in_word_t'{1'b0, 1'b0, 8'h05, 8'hD0, 1'b1});
    send_tick(in_word_t'{1'b1, 1'b1, 8'h05, 8'hD0, 1'b1});
    send_tick(in_word_t'{1'b0, 1'b1, 8'h80, 8'h00, 1'b1});
    send_tick(in_word_t'{1'b1, 1'b1, 8'h7F, 8'h00, 1'b1});
    send_tick(in_word_t'{1'b0, 1'b1, 8'h00, 8'hFF, 1'b1});
    send_tick(in_word_t'{1'b1, 1'b1, 8'h0B, 8'h40, 1'b1});
    send_tick(in_word_t'{1'b0, 1'b1, 8'h05, 8'hE0, 1'b1});
    run_ticks(330);

    // Later phases change the configuration while the block is idle. The
    // first two use the extremes of every register; the others use random
    // and mid-range settings.
    for (int unsigned phase = 1; phase <= 5; phase++) begin
      wait_drained();
      case (phase)
        1: configure(0, 1023, DefPwmPeriod, DefPwmPeriod, DefPwmPeriod, 0, 1);
        2: configure(PitchMax, 0, 0, 0, 0, DefPwmPeriod, 255);
        4: configure(RstTarget, 512, 9000, 7000, 4000, 1000, 7);
        default: begin
          configure($urandom_range(0, PitchMax), $urandom_range(0, 1023),
                    $urandom_range(0, DefPwmPeriod), $urandom_range(0, DefPwmPeriod),
                    $urandom_range(0, DefPwmPeriod), $urandom_range(0, DefPwmPeriod),
                    $urandom_range(1, 30));
        end
      endcase
      run_ticks(330);
    end

    wait_drained();
    if (sb.pending() != 0) begin
      sb.report($sformatf("%0d result words never arrived", sb.pending()));
    end
    if (sb.errors == 0) begin
      $display("[pendulum_balance_drive] OK");
    end else begin
      $display("[pendulum_balance_drive] ERROR");
    end
    $finish;
  end

  // This bound lies far beyond the length of a correct run, even with
  // every gap and stall at its longest.
  initial begin : watchdog
    #10_000_000;
    $display("[pendulum_balance_drive] ERROR");
    $finish;
  end

endmodule

[files.f]
hdl/pbd_pkg.sv
hdl/pbd_if.sv
hdl/pbd_eval.sv
hdl/pendulum_balance_drive.sv
tb/testbench.sv
